// ----- rtl/qrp_pkg.sv -----
// qrp_pkg: shared types and constants of the quaternion point rotation unit
// beat structs, register indexes and fixed-point widths
// no dependencies
package qrp_pkg;

    // fixed-point widths
    localparam int QW    = 16;            // quaternion part, Q2.14
    localparam int CW    = 32;            // coordinate, Q16.16
    localparam int PW    = 2 * QW;        // quaternion product
    localparam int MW    = PW + 2;        // rotation matrix entry, Q6.28
    localparam int DW    = CW + 1;        // vector minus origin
    localparam int SPLIT = 16;            // low part of a split matrix entry
    localparam int HW    = MW - SPLIT;    // high part of a split matrix entry
    localparam int FRAC  = 28;            // fraction bits of a matrix entry
    localparam int PHW   = DW + HW;       // high partial product
    localparam int PLW   = DW + SPLIT + 1; // low partial product
    localparam int SHW   = PHW + 2;       // row sum of high products
    localparam int SLW   = PLW + 2;       // row sum of low products
    localparam int RW    = SHW - (FRAC - SPLIT); // rounded component
    localparam int OW    = RW + 1;        // component plus origin

    localparam logic signed [SLW-1:0] ROUND_HALF = SLW'(64'sd1 <<< (FRAC - 1));

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_W   = 3'd0,
        REG_QUAT_X   = 3'd1,
        REG_QUAT_Y   = 3'd2,
        REG_QUAT_Z   = 3'd3,
        REG_ORIGIN_X = 3'd4,
        REG_ORIGIN_Y = 3'd5,
        REG_ORIGIN_Z = 3'd6
    } cfg_reg_t;

    localparam logic signed [QW-1:0] QUAT_ONE = 16'sd16384;

    typedef struct packed {
        logic              action;
        logic signed [CW-1:0] in_x;
        logic signed [CW-1:0] in_y;
        logic signed [CW-1:0] in_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic              saturated;
    } out_beat_t;

    // action codes
    localparam logic ACT_POINT     = 1'b0;
    localparam logic ACT_DIRECTION = 1'b1;

    typedef logic [2:0][2:0][MW-1:0] rot_mat_t;
    typedef logic [2:0][CW-1:0]      origin_t;

endpackage

// ----- rtl/quaternion_rotate_point_unit.sv -----
// quaternion_rotate_point_unit: top level of the quaternion vector rotation unit
// ties the configuration/matrix block to the rotation pipeline
// depends on qrp_pkg, qrp_matrix, qrp_datapath
//
// rotates one Q16.16 vector per beat by the quaternion held in the configuration
// registers (Q2.14 parts, used as written, no normalization). action selects
// point mode (origin subtracted, vector rotated, origin added back) or direction
// mode (plain rotation). a beat is taken on every clock edge where start is high;
// busy stays low, so a new beat can enter every cycle. done goes high when the beat
// leaves the last pipeline stage, results come in order, and each is
// held for one cycle only: the receiver cannot stall it. the six stages are capture,
// origin subtract, split 33x18 / 33x17 multipliers, row sums, rounding (half toward
// plus infinity), origin add and 32-bit clip. saturated flags any clipped component.
// the matrix is rebuilt from the registers after a write, products first, then the
// matrix entries; write registers only while no beat is in flight.
module quaternion_rotate_point_unit
    import qrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_beat_t             item,
    output logic                 done,
    output out_beat_t            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CW-1:0]        cfg_wdata
);

    rot_mat_t rot;
    origin_t  origin;

    // the pipeline never stalls
    assign busy = 1'b0;

    // config registers and matrix build
    qrp_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rot       (rot),
        .origin    (origin)
    );

    // per-beat rotation pipeline
    qrp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_beat   (item),
        .rot       (rot),
        .origin    (origin),
        .out_valid (done),
        .out_beat  (result)
    );

endmodule

// ----- rtl/qrp_matrix.sv -----
// qrp_matrix: configuration registers and the rotation matrix built from them
// two register stages: quaternion products, then matrix entries
// depends on qrp_pkg
module qrp_matrix
    import qrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CW-1:0]        cfg_wdata,
    output rot_mat_t             rot,
    output origin_t              origin
);

    logic signed [QW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg <= QUAT_ONE;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            oz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_QUAT_W:   qw_reg <= cfg_wdata[QW-1:0];
                REG_QUAT_X:   qx_reg <= cfg_wdata[QW-1:0];
                REG_QUAT_Y:   qy_reg <= cfg_wdata[QW-1:0];
                REG_QUAT_Z:   qz_reg <= cfg_wdata[QW-1:0];
                REG_ORIGIN_X: ox_reg <= cfg_wdata;
                REG_ORIGIN_Y: oy_reg <= cfg_wdata;
                REG_ORIGIN_Z: oz_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign origin = {oz_reg, oy_reg, ox_reg};

    // quaternion products
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, wz_reg, wy_reg, xz_reg, yz_reg, wx_reg;

    always_ff @(posedge clk)
    begin
        ww_reg <= qw_reg * qw_reg;
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        wz_reg <= qw_reg * qz_reg;
        wy_reg <= qw_reg * qy_reg;
        xz_reg <= qx_reg * qz_reg;
        yz_reg <= qy_reg * qz_reg;
        wx_reg <= qw_reg * qx_reg;
    end

    // matrix entries, widened before the sums
    logic signed [MW-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_wy, e_xz, e_yz, e_wx;
    rot_mat_t rot_next, rot_reg;

    assign e_ww = MW'(ww_reg);
    assign e_xx = MW'(xx_reg);
    assign e_yy = MW'(yy_reg);
    assign e_zz = MW'(zz_reg);
    assign e_xy = MW'(xy_reg);
    assign e_wz = MW'(wz_reg);
    assign e_wy = MW'(wy_reg);
    assign e_xz = MW'(xz_reg);
    assign e_yz = MW'(yz_reg);
    assign e_wx = MW'(wx_reg);

    always_comb
    begin
        rot_next[0][0] = e_ww + e_xx - e_yy - e_zz;
        rot_next[0][1] = (e_xy - e_wz) <<< 1;
        rot_next[0][2] = (e_wy + e_xz) <<< 1;
        rot_next[1][0] = (e_xy + e_wz) <<< 1;
        rot_next[1][1] = e_ww - e_xx + e_yy - e_zz;
        rot_next[1][2] = (e_yz - e_wx) <<< 1;
        rot_next[2][0] = (e_xz - e_wy) <<< 1;
        rot_next[2][1] = (e_wx + e_yz) <<< 1;
        rot_next[2][2] = e_ww - e_xx - e_yy + e_zz;
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign rot = rot_reg;

endmodule

// ----- rtl/qrp_datapath.sv -----
// qrp_datapath: six-stage rotation pipeline, one vector per cycle
// capture, origin subtract, split multiply, row sums, rounding, origin add and clip
// depends on qrp_pkg
module qrp_datapath
    import qrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_beat_t  in_beat,
    input  rot_mat_t  rot,
    input  origin_t   origin,
    output logic      out_valid,
    output out_beat_t out_beat
);

    // stage 1: capture
    logic     v1_reg;
    in_beat_t in1_reg;

    // stage 2: vector minus origin
    logic                 v2_reg, pt2_reg;
    logic signed [DW-1:0] c2_reg [3];
    logic signed [DW-1:0] c2_next [3];

    // stage 3: partial products
    logic                  v3_reg, pt3_reg;
    logic signed [PHW-1:0] phi3_reg [3][3], phi3_next [3][3];
    logic signed [PLW-1:0] plo3_reg [3][3], plo3_next [3][3];

    // stage 4: row sums
    logic                  v4_reg, pt4_reg;
    logic signed [SHW-1:0] hi4_reg [3], hi4_next [3];
    logic signed [SLW-1:0] lo4_reg [3], lo4_next [3];

    // stage 5: rounded components
    logic                 v5_reg, pt5_reg;
    logic signed [RW-1:0] r5_reg [3], r5_next [3];

    // stage 6: output
    logic      v6_reg;
    out_beat_t out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_comb
    begin
        logic point;
        point = (in1_reg.action == ACT_POINT);
        c2_next[0] = DW'(in1_reg.in_x) - (point ? DW'($signed(origin[0])) : '0);
        c2_next[1] = DW'(in1_reg.in_y) - (point ? DW'($signed(origin[1])) : '0);
        c2_next[2] = DW'(in1_reg.in_z) - (point ? DW'($signed(origin[2])) : '0);
    end

    // matrix entry split into a signed high part and an unsigned low part
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                phi3_next[i][j] = PHW'(c2_reg[j]) * PHW'($signed(rot[i][j][MW-1:SPLIT]));
                plo3_next[i][j] = PLW'(c2_reg[j])
                                * PLW'($signed({1'b0, rot[i][j][SPLIT-1:0]}));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hi4_next[i] = SHW'(phi3_reg[i][0]) + SHW'(phi3_reg[i][1])
                        + SHW'(phi3_reg[i][2]);
            lo4_next[i] = SLW'(plo3_reg[i][0]) + SLW'(plo3_reg[i][1])
                        + SLW'(plo3_reg[i][2]) + ROUND_HALF;
        end
    end

    // floor of (hi * 2^16 + lo) / 2^28, with the half already in lo
    always_comb
    begin
        logic signed [SHW-1:0] t;
        for (int i = 0; i < 3; i++)
        begin
            t = hi4_reg[i] + SHW'(lo4_reg[i] >>> SPLIT);
            r5_next[i] = t[SHW-1:FRAC-SPLIT];
        end
    end

    always_comb
    begin
        logic signed [OW-1:0] s [3];
        logic signed [CW-1:0] o [3];
        logic                 sat_hi, sat_lo, any_sat;
        any_sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = OW'(r5_reg[i]) + (pt5_reg ? OW'($signed(origin[i])) : '0);
            sat_hi = !s[i][OW-1] && (|s[i][OW-2:CW-1]);
            sat_lo = s[i][OW-1] && !(&s[i][OW-2:CW-1]);
            if (sat_hi)
                o[i] = {1'b0, {(CW-1){1'b1}}};
            else if (sat_lo)
                o[i] = {1'b1, {(CW-1){1'b0}}};
            else
                o[i] = s[i][CW-1:0];
            any_sat = any_sat | sat_hi | sat_lo;
        end
        out_next.out_x     = o[0];
        out_next.out_y     = o[1];
        out_next.out_z     = o[2];
        out_next.saturated = any_sat;
    end

    always_ff @(posedge clk)
    begin
        in1_reg  <= in_beat;
        c2_reg   <= c2_next;
        pt2_reg  <= (in1_reg.action == ACT_POINT);
        phi3_reg <= phi3_next;
        plo3_reg <= plo3_next;
        pt3_reg  <= pt2_reg;
        hi4_reg  <= hi4_next;
        lo4_reg  <= lo4_next;
        pt4_reg  <= pt3_reg;
        r5_reg   <= r5_next;
        pt5_reg  <= pt4_reg;
        out_reg  <= out_next;
    end

    assign out_valid = v6_reg;
    assign out_beat  = out_reg;

endmodule

// ----- rtl/qrp_checker.sv -----
// qrp_checker: port-level assertions for the quaternion rotation unit
// bound to quaternion_rotate_point_unit; depends on qrp_pkg
module qrp_checker
    import qrp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_beat_t result
);

    localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] NEG_MAX = {1'b1, {(CW-1){1'b0}}};

    // a result only ever follows an earlier accepted beat
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without an accepted beat");

    // every accepted beat yields its result if reset stays off meanwhile
    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy, 6) && $past(rst_n, 6) && $past(rst_n, 5)
         && $past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2)
         && $past(rst_n, 1)) |-> done)
        else $error("accepted beat lost");

    // the flag only when some component sits at a limit
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated) |->
            (result.out_x == POS_MAX || result.out_x == NEG_MAX
             || result.out_y == POS_MAX || result.out_y == NEG_MAX
             || result.out_z == POS_MAX || result.out_z == NEG_MAX))
        else $error("saturated flag without a clipped component");

    // the unit never holds off a beat
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised");

endmodule

bind quaternion_rotate_point_unit qrp_checker u_qrp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- sim/qrp_checker.sv -----
// qrp_scoreboard: watches the beat, result and register ports of the rotation unit
// predicts every rotated vector and compares it with the result beats
// depends on qrp_pkg
module qrp_scoreboard
    import qrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  in_beat_t             item,
    input  logic                 done,
    input  out_beat_t            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CW-1:0]        cfg_wdata,
    output int                   fail_count,
    output int                   pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    // more slots than beats a whole run sends
    localparam int     EXP_DEPTH = 1024;

    // shadow copy of the register file
    logic signed [QW-1:0] q_w, q_x, q_y, q_z;
    logic signed [CW-1:0] orig_x, orig_y, orig_z;

    // expected results in arrival order, written at exp_wr and read at exp_rd
    out_beat_t expected_rotations [EXP_DEPTH];
    int        exp_wr;
    int        exp_rd;
    int        mismatches;
    int        result_beats;

    function automatic out_beat_t rotate_vector(in_beat_t b);
        longint            w, x, y, z;
        longint            ww, xx, yy, zz;
        longint            m[3][3];
        longint            org[3];
        longint            c[3];
        longint            r[3];
        logic signed [95:0] acc, mm, cc;
        logic              clipped;
        out_beat_t         o;
        w = q_w;
        x = q_x;
        y = q_y;
        z = q_z;
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        m[0][0] = ww + xx - yy - zz;
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (w * y + x * z);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = ww - xx + yy - zz;
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (w * x + y * z);
        m[2][2] = ww - xx - yy + zz;
        if (b.action == ACT_POINT)
        begin
            org[0] = orig_x;
            org[1] = orig_y;
            org[2] = orig_z;
        end
        else
        begin
            org[0] = 0;
            org[1] = 0;
            org[2] = 0;
        end
        c[0] = longint'($signed(b.in_x)) - org[0];
        c[1] = longint'($signed(b.in_y)) - org[1];
        c[2] = longint'($signed(b.in_z)) - org[2];
        clipped = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
            begin
                mm = m[i][j];
                cc = c[j];
                acc = acc + mm * cc;
            end
            // round half toward plus infinity, then back to q16.16
            acc = (acc + (96'sd1 <<< (FRAC - 1))) >>> FRAC;
            r[i] = acc[63:0];
            r[i] = r[i] + org[i];
            if (r[i] > COORD_MAX)
            begin
                r[i] = COORD_MAX;
                clipped = 1'b1;
            end
            else if (r[i] < COORD_MIN)
            begin
                r[i] = COORD_MIN;
                clipped = 1'b1;
            end
        end
        o.out_x = r[0][CW-1:0];
        o.out_y = r[1][CW-1:0];
        o.out_z = r[2][CW-1:0];
        o.saturated = clipped;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            q_w = QUAT_ONE;
            q_x = '0;
            q_y = '0;
            q_z = '0;
            orig_x = '0;
            orig_y = '0;
            orig_z = '0;
            exp_wr = 0;
            exp_rd = 0;
            mismatches = 0;
            result_beats = 0;
            fail_count <= 0;
            pending_beats <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUAT_W:   q_w = cfg_wdata[QW-1:0];
                    REG_QUAT_X:   q_x = cfg_wdata[QW-1:0];
                    REG_QUAT_Y:   q_y = cfg_wdata[QW-1:0];
                    REG_QUAT_Z:   q_z = cfg_wdata[QW-1:0];
                    REG_ORIGIN_X: orig_x = cfg_wdata;
                    REG_ORIGIN_Y: orig_y = cfg_wdata;
                    REG_ORIGIN_Z: orig_z = cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                expected_rotations[exp_wr % EXP_DEPTH] = rotate_vector(item);
                exp_wr++;
            end
            if (done)
            begin
                if (exp_wr == exp_rd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat %0d with nothing expected: %h %h %h sat=%b",
                                 result_beats, result.out_x, result.out_y,
                                 result.out_z, result.saturated);
                end
                else
                begin
                    want = expected_rotations[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
                        result.out_z !== want.out_z || result.saturated !== want.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result beat %0d mismatch: expected %h %h %h sat=%b",
                                     result_beats, want.out_x, want.out_y, want.out_z,
                                     want.saturated);
                            $display("    got %h %h %h sat=%b",
                                     result.out_x, result.out_y, result.out_z,
                                     result.saturated);
                        end
                    end
                end
                result_beats++;
            end
            fail_count <= mismatches;
            pending_beats <= exp_wr - exp_rd;
        end
    end

endmodule

// ----- sim/tb.sv -----
// tb: stimulus and verdict for the quaternion point rotation unit
// drives vector beats and register writes, the scoreboard does the comparing
// depends on qrp_pkg, qrp_scoreboard, quaternion_rotate_point_unit
module tb
    import qrp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // index past the end of the register list, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [CW-1:0] C_MAX  = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] C_MIN  = 32'h8000_0000;
    localparam logic [CW-1:0] C_ONE  = 32'h0001_0000;   // 1.0 in q16.16

    // phase count and per-phase size of the random part
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 100;
    // covers the result pipeline plus the matrix rebuild
    localparam int SETTLE     = 8;
    localparam int DRAIN_GUARD = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_beat_t             item_beat;
    logic                 done;
    out_beat_t            result_beat;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0]        cfg_wdata;

    int fail_count;
    int pending_beats;
    // chance in percent that the sender idles before a beat, drawn anew after each gap
    int idle_pct;

    quaternion_rotate_point_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_beat),
        .done      (done),
        .result    (result_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // scoreboard sits beside the block and only watches its ports
    qrp_scoreboard u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item_beat),
        .done          (done),
        .result        (result_beat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // hand one vector beat to the block
    // entered and left at a falling edge; start stays high on the way out so
    // back-to-back beats never drop it within one step
    task automatic send_vector(logic act, logic [CW-1:0] vx, logic [CW-1:0] vy,
                               logic [CW-1:0] vz);
        in_beat_t b;
        b.action = act;
        b.in_x = vx;
        b.in_y = vy;
        b.in_z = vz;
        // random gaps before the beat
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item_beat <= {1'($urandom), $urandom, $urandom, $urandom};
            @(negedge clk);
        end
        start <= 1'b1;
        item_beat <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop start and wait until every predicted result has come back,
    // then let the pipeline and the matrix rebuild settle
    task automatic drain_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // one register write, cfg_we left high for a following write
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // full register load, only called while the block is idle
    // quaternion words may carry junk in the upper half, only 16 bits count
    task automatic load_config(logic [CW-1:0] w, logic [CW-1:0] x, logic [CW-1:0] y,
                               logic [CW-1:0] z, logic [CW-1:0] ox, logic [CW-1:0] oy,
                               logic [CW-1:0] oz, bit poke_unused);
        put_reg(REG_QUAT_W, w);
        put_reg(REG_QUAT_X, x);
        if (poke_unused)
            put_reg(REG_UNUSED, $urandom);
        put_reg(REG_QUAT_Y, y);
        put_reg(REG_QUAT_Z, z);
        put_reg(REG_ORIGIN_X, ox);
        put_reg(REG_ORIGIN_Y, oy);
        put_reg(REG_ORIGIN_Z, oz);
        cfg_we <= 1'b0;
        cfg_wdata <= $urandom;
        // matrix is rebuilt from the registers after the last write
        repeat (SETTLE) @(negedge clk);
    endtask

    // coordinate mix: mostly full range, some small values and the extremes
    function automatic logic [CW-1:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return $urandom;
        else if (pick < 8)
            return CW'($urandom_range(2097151)) - 32'd1048576;
        else if (pick == 8)
            return C_MAX;
        else
            return C_MIN;
    endfunction

    // quaternion part mix: unit-range values, the edges of that range, and
    // raw 16-bit words (parts beyond one, upper bits of the write word random)
    function automatic logic [CW-1:0] rand_quat_part();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 32'd16384;
            1: return -32'sd16384;
            2: return 32'd0;
            7, 8: return $urandom;
            9: return 32'd11585;   // cos of 45 degrees
            default: return CW'($urandom_range(32768)) - 32'd16384;
        endcase
    endfunction

    initial
    begin
        // every input known from time zero
        rst_n = 1'b0;
        start = 1'b0;
        item_beat = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        idle_pct = 25;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(negedge clk);

        // ---- directed part ----

        // reset registers: identity rotation, origin zero
        send_vector(ACT_POINT, 32'd0, 32'd0, 32'd0);
        send_vector(ACT_POINT, C_MAX, C_MIN, 32'd1);
        send_vector(ACT_DIRECTION, C_MIN, C_MAX, 32'hFFFF_FFFF);
        send_vector(ACT_DIRECTION, C_ONE, -C_ONE, 32'h1234_5678);
        drain_results();

        // parts far outside unit length, every part at the negative extreme,
        // origin x and y at the coordinate extremes: heavy scaling and clipping
        load_config(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000,
                    C_MAX, C_MIN, 32'd0, 1'b0);
        send_vector(ACT_POINT, C_MIN, C_MAX, 32'd0);
        send_vector(ACT_DIRECTION, C_MAX, C_MAX, C_MAX);
        send_vector(ACT_DIRECTION, 32'd1, 32'd1, 32'd1);
        send_vector(ACT_POINT, 32'd0, 32'd0, 32'd0);
        drain_results();

        // quarter turn about z around an off-zero centre
        load_config(32'd11585, 32'd0, 32'd0, 32'd11585, C_ONE, -(2 * C_ONE), C_MIN, 1'b0);
        send_vector(ACT_POINT, 2 * C_ONE, -(2 * C_ONE), C_MIN);
        send_vector(ACT_POINT, C_MAX, C_MAX, C_MAX);
        send_vector(ACT_DIRECTION, C_ONE, 32'd0, 32'd0);
        drain_results();

        // half-length scalar part: quarter scale, so exact halves show the
        // rounding toward plus infinity; unused index written in between
        load_config(32'd8192, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        send_vector(ACT_DIRECTION, 32'd2, -32'sd2, 32'd6);
        send_vector(ACT_DIRECTION, -32'sd6, 32'd1, -32'sd1);
        send_vector(ACT_POINT, 32'd10, -32'sd10, 32'd14);
        drain_results();

        // unit-range extremes on every part, non-unit norm, extreme centres
        load_config(-32'sd16384, 32'd16384, -32'sd16384, 32'd16384,
                    C_MIN, C_MAX, C_MAX, 1'b1);
        send_vector(ACT_POINT, C_MAX, C_MIN, 32'd0);
        send_vector(ACT_POINT, C_MIN, C_MIN, C_MIN);
        send_vector(ACT_DIRECTION, 32'd3, -32'sd5, 32'd7);
        send_vector(ACT_DIRECTION, C_MIN, C_MIN, C_MAX);
        drain_results();

        // ---- random part ----
        // sender idles a quarter of the time, then most of the time, then never;
        // each phase ends with a full drain before the registers change
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 3)
                idle_pct = 25;
            else if (ph < 6)
                idle_pct = 84;
            else
                idle_pct = 0;
            load_config(rand_quat_part(), rand_quat_part(), rand_quat_part(),
                        rand_quat_part(), rand_coord(), rand_coord(), rand_coord(),
                        ($urandom_range(3) == 0));
            for (int n = 0; n < PHASE_LEN; n++)
                send_vector(1'($urandom), rand_coord(), rand_coord(), rand_coord());
            drain_results();
        end

        if (fail_count == 0 && pending_beats == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- quaternion_rotate_point_unit.f -----
rtl/qrp_pkg.sv
rtl/qrp_matrix.sv
rtl/qrp_datapath.sv
rtl/quaternion_rotate_point_unit.sv
rtl/qrp_checker.sv
sim/qrp_checker.sv
sim/tb.sv
